@@ rtl/core/assert_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the read trim filter RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define RQTF_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rqtf assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is high.
`define RQTF_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rqtf assertion failed: next-cycle implication");

`endif

@@ rtl/core/rqtf_pkg.sv @@
// ---------------------------------------------------------------------------
// rqtf_pkg
// Types, widths and constants shared by the read quality trim filter.
// ---------------------------------------------------------------------------
`default_nettype none

package rqtf_pkg;

   // Field widths.
   localparam int unsigned LEN_W      = 13;
   localparam int unsigned SUM_W      = 40;
   localparam int unsigned CHAR_W     = 8;
   localparam int unsigned TLEN_W     = 14;
   localparam int unsigned TQUAL_W    = 7;
   localparam int unsigned QV_W       = 10;
   localparam int unsigned VERDICT_W  = 2;
   localparam int unsigned CSR_IDX_W  = 3;
   localparam int unsigned CSR_DATA_W = 40;
   localparam int unsigned REQ_DATA_W = 32;
   localparam int unsigned RSP_DATA_W = 72;

   // Read and quality limits.
   localparam int MAX_LEN     = 4096;
   localparam int QUAL_OFFSET = 33;
   localparam int QUAL_MIN    = 0;
   localparam int QUAL_MAX    = 41;
   localparam int QTAB_DEPTH  = QUAL_MAX - QUAL_MIN + 1;
   localparam int QIDX_W      = $clog2(QTAB_DEPTH);
   localparam logic [LEN_W-1:0] POS_MAX = LEN_W'((2 ** LEN_W) - 1);

   // Queue between the front and back ends.
   localparam int FIFO_DEPTH = 2;
   localparam int FIFO_PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
   localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

   // Ambiguous base letters.
   localparam logic [CHAR_W-1:0] CHAR_N_UPPER = 8'h4E;
   localparam logic [CHAR_W-1:0] CHAR_N_LOWER = 8'h6E;

   // Verdict codes.
   localparam logic [VERDICT_W-1:0] VERDICT_KEEP    = 2'd0;
   localparam logic [VERDICT_W-1:0] VERDICT_DISCARD = 2'd1;
   localparam logic [VERDICT_W-1:0] VERDICT_RANGE   = 2'd2;

   // Register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_STRIP_LEFT  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_STRIP_RIGHT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TRUNC_LEN   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_TRUNC_QUAL  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_TRUNC_EE    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_EE      = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_LEN     = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_NS      = 3'd7;

   // Error probability mantissas, 10^(12 - r/10) rounded.
   localparam logic [64:0] DECADE_MANT [10] = '{
      65'd1000000000000, 65'd794328234724, 65'd630957344480, 65'd501187233627,
      65'd398107170553,  65'd316227766017, 65'd251188643151, 65'd199526231497,
      65'd158489319246,  65'd125892541179
   };

   // Divisors 10^(12+d) for decades d = -1 .. 7.
   localparam logic [64:0] POW10 [9] = '{
      65'd100000000000, 65'd1000000000000, 65'd10000000000000,
      65'd100000000000000, 65'd1000000000000000, 65'd10000000000000000,
      65'd100000000000000000, 65'd1000000000000000000,
      65'd10000000000000000000
   };

   // Configuration register file.
   typedef struct packed {
      logic [LEN_W-1:0]          strip_left;
      logic [LEN_W-1:0]          strip_right;
      logic signed [TLEN_W-1:0]  trunc_len;
      logic signed [TQUAL_W-1:0] trunc_qual;
      logic [SUM_W-1:0]          trunc_ee;
      logic [SUM_W-1:0]          max_ee;
      logic [LEN_W-1:0]          min_len;
      logic [LEN_W-1:0]          max_ns;
   } cfg_type;

   // One classified base handed from the front to the back end.
   typedef struct packed {
      logic             in_win;
      logic             has_q;
      logic             q_ok;
      logic             q_trunc;
      logic [SUM_W-1:0] err;
      logic             is_n;
      logic             last;
      logic [LEN_W-1:0] start;
      logic [LEN_W-1:0] wlen;
      logic [LEN_W-1:0] len;
   } entry_type;

endpackage

`default_nettype wire

@@ rtl/core/rqtf_fifo.sv @@
// ---------------------------------------------------------------------------
// rqtf_fifo
// Short first-word-fall-through queue between the front and back ends.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module rqtf_fifo (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 push_valid,
   output logic                push_ready,
   input  rqtf_pkg::entry_type push_data,
   output logic                pop_valid,
   input  wire                 pop,
   output rqtf_pkg::entry_type pop_data
);
   import rqtf_pkg::*;

   entry_type              mem_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [FIFO_PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [FIFO_CNT_W-1:0]  count_ff, count_in;
   logic                   do_push;

   // Flow control.
   assign push_ready = (count_ff != FIFO_CNT_W'(FIFO_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign do_push    = push_valid && push_ready;
   assign pop_data   = mem_ff[rd_ptr_ff];

   // Pointer and fill count updates.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   // Checks.
   `RQTF_ASSERT_IMPL(a_count_bound, clock, reset, 1'b1, count_ff <= FIFO_CNT_W'(FIFO_DEPTH))
   `RQTF_ASSERT_NEXT(a_pop_drains, clock, reset, pop && !do_push, count_ff == $past(count_ff) - 1'b1)
   `RQTF_ASSERT_IMPL(a_pop_nonempty, clock, reset, pop, pop_valid)

endmodule

`default_nettype wire

@@ rtl/core/rqtf_front.sv @@
// ---------------------------------------------------------------------------
// rqtf_front
// Accepts base beats, tracks the read position, computes the trim window
// and classifies each base (window membership, quality range, error value).
// ---------------------------------------------------------------------------
`default_nettype none

module rqtf_front (
   input  wire                                  clock,
   input  wire                                  reset,
   input  rqtf_pkg::cfg_type                    cfg,
   input  wire                                  req_tvalid,
   output logic                                 req_tready,
   input  wire  [rqtf_pkg::REQ_DATA_W-1:0]      req_tdata,
   input  wire                                  req_tuser,
   input  wire                                  req_tlast,
   output logic                                 push_valid,
   input  wire                                  push_ready,
   output rqtf_pkg::entry_type                  push_data
);
   import rqtf_pkg::*;

   logic [LEN_W-1:0]       pos_ff, pos_in;
   logic [CHAR_W-1:0]      base_char;
   logic [CHAR_W-1:0]      qual_char;
   logic [LEN_W-1:0]       read_length;
   logic [LEN_W-1:0]       len_c;
   logic [LEN_W-1:0]       start;
   logic [LEN_W-1:0]       rest;
   logic [LEN_W-1:0]       wl_strip;
   logic [LEN_W-1:0]       wlen;
   logic [LEN_W:0]         win_end;
   logic signed [QV_W-1:0] qv;
   logic [QV_W-1:0]        qoff;
   logic                   q_ok;
   logic                   accept;
   logic [SUM_W-1:0]       err_rom [QTAB_DEPTH];

   // Error probability table, UQ16.24, built at elaboration.
   for (genvar q = QUAL_MIN; q <= QUAL_MAX; q++) begin : g_err
      localparam int QC = (q < -10) ? -10 : q;
      localparam int DC = (QC >= 0) ? (QC / 10) : -1;
      localparam int RC = QC - (10 * DC);
      localparam int DI = (DC >= 8) ? 7 : DC;
      localparam logic [64:0] XV = DECADE_MANT[RC] << 24;
      localparam logic [64:0] DV = POW10[DI + 1];
      localparam logic [64:0] EV = (DC >= 8) ? 65'd0 : ((XV + (DV / 2)) / DV);
      assign err_rom[q - QUAL_MIN] = EV[SUM_W-1:0];
   end

   // Beat fields: base, quality, raw read length.
   assign base_char   = req_tdata[7:0];
   assign qual_char   = req_tdata[15:8];
   assign read_length = req_tdata[28:16];

   assign req_tready = push_ready;
   assign push_valid = req_tvalid;
   assign accept     = req_tvalid && push_ready;

   // Trim window from the clamped read length.
   always_comb begin
      len_c    = (read_length > LEN_W'(MAX_LEN)) ? LEN_W'(MAX_LEN) : read_length;
      start    = (cfg.strip_left < len_c) ? cfg.strip_left : len_c;
      rest     = len_c - start;
      wl_strip = (cfg.strip_right < rest) ? (rest - cfg.strip_right) : '0;
      wlen     = wl_strip;
      if (!cfg.trunc_len[TLEN_W-1] && ($unsigned(cfg.trunc_len) < {1'b0, wl_strip})) begin
         wlen = cfg.trunc_len[LEN_W-1:0];
      end
      win_end = {1'b0, start} + {1'b0, wlen};
   end

   // Quality value and its classification.
   assign qv   = $signed({2'b00, qual_char}) - QV_W'(QUAL_OFFSET);
   assign q_ok = (qv >= QV_W'(QUAL_MIN)) && (qv <= QV_W'(QUAL_MAX));
   assign qoff = qv - QV_W'(QUAL_MIN);

   always_comb begin
      push_data.in_win  = (pos_ff < len_c) && (pos_ff >= start) && ({1'b0, pos_ff} < win_end);
      push_data.has_q   = req_tuser;
      push_data.q_ok    = q_ok;
      push_data.q_trunc = !cfg.trunc_qual[TQUAL_W-1] && (qv <= QV_W'(cfg.trunc_qual));
      push_data.err     = q_ok ? err_rom[qoff[QIDX_W-1:0]] : '0;
      push_data.is_n    = (base_char == CHAR_N_UPPER) || (base_char == CHAR_N_LOWER);
      push_data.last    = req_tlast;
      push_data.start   = start;
      push_data.wlen    = wlen;
      push_data.len     = len_c;
   end

   // Position within the current read, saturating.
   always_comb begin
      pos_in = pos_ff;
      if (accept) begin
         if (req_tlast) begin
            pos_in = '0;
         end else if (pos_ff != POS_MAX) begin
            pos_in = pos_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
      end else begin
         pos_ff <= pos_in;
      end
   end

endmodule

`default_nettype wire

@@ rtl/core/rqtf_back.sv @@
// ---------------------------------------------------------------------------
// rqtf_back
// Applies classified bases to the per-read state (error sum, truncation,
// N count) and forms the verdict beat on the last base of each read.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module rqtf_back (
   input  wire                              clock,
   input  wire                              reset,
   input  rqtf_pkg::cfg_type                cfg,
   input  wire                              head_valid,
   input  rqtf_pkg::entry_type              head_data,
   output logic                             pop,
   output logic                             rsp_tvalid,
   input  wire                              rsp_tready,
   output logic [rqtf_pkg::RSP_DATA_W-1:0]  rsp_tdata
);
   import rqtf_pkg::*;

   logic [SUM_W-1:0]     sum_ff, sum_in;
   logic [LEN_W-1:0]     wl_ff, wl_in;
   logic [LEN_W-1:0]     n_ff, n_in;
   logic                 stop_ff, stop_in;
   logic                 rerr_ff, rerr_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [VERDICT_W-1:0] verdict_ff, verdict_in;
   logic                 trunc_ff, trunc_in;
   logic [LEN_W-1:0]     start_ff, start_in;
   logic [LEN_W-1:0]     flen_ff, flen_in;
   logic [SUM_W-1:0]     ee_ff, ee_in;

   logic                 active;
   logic [SUM_W:0]       sum_plus;
   logic                 over_trunc;
   logic                 take_sum;
   logic                 set_stop;
   logic                 set_rerr;
   logic                 take_base;
   logic [SUM_W-1:0]     sum_nx;
   logic [LEN_W-1:0]     wl_nx;
   logic [LEN_W-1:0]     n_nx;
   logic                 stop_nx;
   logic                 rerr_nx;
   logic                 ee_over;
   logic [LEN_W-1:0]     final_len;
   logic                 discard;
   logic                 emit;

   // The head leaves the queue unless it closes a read and the output is held.
   assign pop  = head_valid && (!head_data.last || !rsp_valid_ff || rsp_tready);
   assign emit = pop && head_data.last;

   // Running sum and the truncation limit check.
   assign active     = head_data.in_win && !stop_ff && !rerr_ff;
   assign sum_plus   = {1'b0, sum_ff} + {1'b0, head_data.err};
   assign over_trunc = sum_plus > {1'b0, cfg.trunc_ee};

   always_comb begin
      take_sum  = 1'b0;
      set_stop  = 1'b0;
      set_rerr  = 1'b0;
      take_base = 1'b0;
      if (active) begin
         if (head_data.has_q) begin
            if (!head_data.q_ok) begin
               set_rerr = 1'b1;
            end else if (head_data.q_trunc || over_trunc) begin
               set_stop = 1'b1;
            end else begin
               take_sum  = 1'b1;
               take_base = 1'b1;
            end
         end else begin
            take_base = 1'b1;
         end
      end
   end

   // State after this base.
   always_comb begin
      sum_nx  = take_sum ? sum_plus[SUM_W-1:0] : sum_ff;
      stop_nx = stop_ff || set_stop;
      rerr_nx = rerr_ff || set_rerr;
      wl_nx   = wl_ff;
      n_nx    = n_ff;
      if (take_base && (wl_ff != POS_MAX)) begin
         wl_nx = wl_ff + 1'b1;
      end
      if (take_base && head_data.is_n && (n_ff != POS_MAX)) begin
         n_nx = n_ff + 1'b1;
      end
   end

   // Verdict for a read that closes with this base.
   always_comb begin
      ee_over   = take_sum ? (sum_plus > {1'b0, cfg.max_ee}) : (sum_ff > cfg.max_ee);
      final_len = stop_nx ? wl_nx : head_data.wlen;
      discard   = (head_data.has_q && ee_over)
               || (!cfg.trunc_len[TLEN_W-1] && ({1'b0, final_len} < $unsigned(cfg.trunc_len)))
               || (final_len < cfg.min_len)
               || (n_nx > cfg.max_ns);
   end

   // Per-read state: cleared after the last base of each read.
   always_comb begin
      sum_in  = sum_ff;
      wl_in   = wl_ff;
      n_in    = n_ff;
      stop_in = stop_ff;
      rerr_in = rerr_ff;
      if (pop) begin
         if (head_data.last) begin
            sum_in  = '0;
            wl_in   = '0;
            n_in    = '0;
            stop_in = 1'b0;
            rerr_in = 1'b0;
         end else begin
            sum_in  = sum_nx;
            wl_in   = wl_nx;
            n_in    = n_nx;
            stop_in = stop_nx;
            rerr_in = rerr_nx;
         end
      end
   end

   // Output register contents.
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      verdict_in   = verdict_ff;
      trunc_in     = trunc_ff;
      start_in     = start_ff;
      flen_in      = flen_ff;
      ee_in        = ee_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         if (rerr_nx) begin
            verdict_in = VERDICT_RANGE;
            trunc_in   = 1'b0;
            start_in   = '0;
            flen_in    = '0;
            ee_in      = '0;
         end else begin
            verdict_in = discard ? VERDICT_DISCARD : VERDICT_KEEP;
            trunc_in   = final_len < head_data.len;
            start_in   = head_data.start;
            flen_in    = final_len;
            ee_in      = head_data.has_q ? sum_nx : '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff       <= '0;
         wl_ff        <= '0;
         n_ff         <= '0;
         stop_ff      <= 1'b0;
         rerr_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         sum_ff       <= sum_in;
         wl_ff        <= wl_in;
         n_ff         <= n_in;
         stop_ff      <= stop_in;
         rerr_ff      <= rerr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      verdict_ff <= verdict_in;
      trunc_ff   <= trunc_in;
      start_ff   <= start_in;
      flen_ff    <= flen_in;
      ee_ff      <= ee_in;
   end

   // Result beat: verdict, truncated flag, start, length, expected errors.
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, ee_ff, flen_ff, start_ff, trunc_ff, verdict_ff};

   // Checks.
   `RQTF_ASSERT_IMPL(a_range_zero, clock, reset, rsp_valid_ff && (verdict_ff == VERDICT_RANGE), (flen_ff == '0) && (start_ff == '0) && (ee_ff == '0) && !trunc_ff)
   `RQTF_ASSERT_IMPL(a_keep_min_len, clock, reset, rsp_valid_ff && (verdict_ff == VERDICT_KEEP), flen_ff >= cfg.min_len)
   `RQTF_ASSERT_NEXT(a_stop_holds, clock, reset, stop_ff && !emit, stop_ff)

endmodule

`default_nettype wire

@@ rtl/core/read_quality_trim_filter_core.sv @@
// ---------------------------------------------------------------------------
// read_quality_trim_filter_core
// Expected-error quality trim and filter for sequencing reads, one base per
// beat, with one verdict beat per read.
// ---------------------------------------------------------------------------
// Throughput: one base beat per cycle while the queue has room; a held verdict
// beat stalls the input. The sum, limit compare and truncation update in the
// back end are combinational ahead of the per-read state registers.
// Path: the read's last beat is written into the queue when accepted, and its
// verdict beat is loaded into the output register from the queue head.
// Reset: synchronous; clears read state and the queue, and loads register
// defaults (trunc_len, trunc_qual off; ee limits all ones; min_len 1).
// ---------------------------------------------------------------------------
`default_nettype none

module read_quality_trim_filter_core (
   input  wire                                  clock,
   input  wire                                  reset,
   // Configuration write port.
   input  wire                                  csr_we,
   input  wire  [rqtf_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire  [rqtf_pkg::CSR_DATA_W-1:0]      csr_wdata,
   // Base beats.
   input  wire                                  req_tvalid,
   output logic                                 req_tready,
   // tdata: base_char[7:0], qual_char[15:8], read_length[28:16], zero pad
   input  wire  [rqtf_pkg::REQ_DATA_W-1:0]      req_tdata,
   // tuser: has_quality
   input  wire                                  req_tuser,
   input  wire                                  req_tlast,
   // Verdict beats.
   output logic                                 rsp_tvalid,
   input  wire                                  rsp_tready,
   // tdata: verdict[1:0], was_truncated[2], window_start[15:3],
   //        final_length[28:16], expected_errors[68:29], zero pad
   output logic [rqtf_pkg::RSP_DATA_W-1:0]      rsp_tdata
);
   import rqtf_pkg::*;

   cfg_type   cfg_ff, cfg_in;
   entry_type push_data;
   entry_type head_data;
   logic      push_valid;
   logic      push_ready;
   logic      head_valid;
   logic      pop;

   // Register writes.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_STRIP_LEFT:  cfg_in.strip_left  = csr_wdata[LEN_W-1:0];
            CSR_STRIP_RIGHT: cfg_in.strip_right = csr_wdata[LEN_W-1:0];
            CSR_TRUNC_LEN:   cfg_in.trunc_len   = csr_wdata[TLEN_W-1:0];
            CSR_TRUNC_QUAL:  cfg_in.trunc_qual  = csr_wdata[TQUAL_W-1:0];
            CSR_TRUNC_EE:    cfg_in.trunc_ee    = csr_wdata[SUM_W-1:0];
            CSR_MAX_EE:      cfg_in.max_ee      = csr_wdata[SUM_W-1:0];
            CSR_MIN_LEN:     cfg_in.min_len     = csr_wdata[LEN_W-1:0];
            CSR_MAX_NS:      cfg_in.max_ns      = csr_wdata[LEN_W-1:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.strip_left  <= '0;
         cfg_ff.strip_right <= '0;
         cfg_ff.trunc_len   <= '1;
         cfg_ff.trunc_qual  <= '1;
         cfg_ff.trunc_ee    <= '1;
         cfg_ff.max_ee      <= '1;
         cfg_ff.min_len     <= LEN_W'(1);
         cfg_ff.max_ns      <= LEN_W'(MAX_LEN);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Front end: window and classification.
   rqtf_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   // Queue between the two ends.
   rqtf_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (head_valid),
      .pop        (pop),
      .pop_data   (head_data)
   );

   // Back end: accumulation and verdict.
   rqtf_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .head_valid (head_valid),
      .head_data  (head_data),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

`default_nettype wire
